/* rtl/csma_pkg.sv */
package csma_pkg;

  // Command codes carried on the input channel.
  localparam logic [2:0] CmdStart = 3'd0;
  localparam logic [2:0] CmdTick  = 3'd1;
  localparam logic [2:0] CmdIdle  = 3'd2;
  localparam logic [2:0] CmdBusy  = 3'd3;
  localparam logic [2:0] CmdError = 3'd4;

  // Outcome codes carried on the result channel.
  localparam logic [1:0] OutNone = 2'd0;
  localparam logic [1:0] OutCca  = 2'd1;
  localparam logic [1:0] OutOk   = 2'd2;
  localparam logic [1:0] OutFail = 2'd3;

  // Register indexes, taken from paddr[3:2].
  localparam logic [1:0] RegMaxBackoffs = 2'd0;
  localparam logic [1:0] RegMinExponent = 2'd1;
  localparam logic [1:0] RegMaxExponent = 2'd2;

  // Register reset values.
  localparam logic [3:0] MaxBackoffsRst = 4'd4;
  localparam logic [3:0] MinExponentRst = 4'd3;
  localparam logic [3:0] MaxExponentRst = 4'd5;

  // The try count saturates at its all-ones value.
  localparam logic [4:0] TryMax = 5'd31;

  typedef struct packed {
    logic [3:0] max_backoffs;
    logic [3:0] min_exponent;
    logic [3:0] max_exponent;
  } cfg_t;

endpackage

/* rtl/csma_cfg_regs.sv */
module csma_cfg_regs import csma_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  cfg_t cfg_q;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_backoffs <= MaxBackoffsRst;
      cfg_q.min_exponent <= MinExponentRst;
      cfg_q.max_exponent <= MaxExponentRst;
    end else if (wr_en) begin
      case (paddr[3:2])
        RegMaxBackoffs: cfg_q.max_backoffs <= pwdata[3:0];
        RegMinExponent: cfg_q.min_exponent <= pwdata[3:0];
        RegMaxExponent: cfg_q.max_exponent <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      RegMaxBackoffs: prdata = {28'd0, cfg_q.max_backoffs};
      RegMinExponent: prdata = {28'd0, cfg_q.min_exponent};
      RegMaxExponent: prdata = {28'd0, cfg_q.max_exponent};
      default:        prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/csma_in_stage.sv */
module csma_in_stage import csma_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_valid_i,
  output logic       s_ready_o,
  input  logic [2:0] s_cmd_i,
  input  logic [7:0] s_rnd_i,
  output logic       valid_o,
  input  logic       pop_i,
  output logic [2:0] cmd_o,
  output logic [7:0] rnd_o
);

  logic       valid_q;
  logic [2:0] cmd_q;
  logic [7:0] rnd_q;
  logic       load;

  // The register takes a new word whenever it is empty or drains this cycle.
  assign s_ready_o = ~valid_q | pop_i;
  assign load      = s_valid_i & s_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (s_ready_o) begin
      valid_q <= s_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cmd_q <= s_cmd_i;
      rnd_q <= s_rnd_i;
    end
  end

  assign valid_o = valid_q;
  assign cmd_o   = cmd_q;
  assign rnd_o   = rnd_q;

endmodule

/* rtl/csma_engine.sv */
module csma_engine import csma_pkg::*; #(
  parameter int unsigned UNIT_PERIOD = 20
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       in_valid_i,
  output logic       in_pop_o,
  input  logic [2:0] cmd_i,
  input  logic [7:0] rnd_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] outcome_o,
  output logic       waiting_o
);

  localparam int unsigned PerW = $clog2(UNIT_PERIOD + 1);
  localparam int unsigned CntW = 8 + PerW + 4;

  logic [4:0]      try_q, try_d;
  logic [3:0]      exp_q, exp_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            counting_q, counting_d;

  logic            out_valid_q;
  logic [1:0]      outcome_q;
  logic            waiting_q;
  logic [1:0]      outcome_d;

  logic            advance;
  logic [4:0]      base_try;
  logic [3:0]      base_exp;
  logic [4:0]      fire_try;
  logic [4:0]      exp_inc;
  logic [3:0]      fire_exp;
  logic [7:0]      mask;
  logic [7:0]      masked;
  logic [8+PerW-1:0] prod;
  logic [CntW-1:0] wait_val;
  logic [CntW-1:0] cnt_dec;

  assign advance  = in_valid_i & (~out_valid_q | out_ready_i);
  assign in_pop_o = advance;

  // Start reloads try count and exponent before the draw.
  assign base_try = (cmd_i == CmdStart) ? 5'd0 : try_q;
  assign base_exp = (cmd_i == CmdStart) ? cfg_i.min_exponent : exp_q;

  // Values left behind when the engine fires a CCA request.
  assign fire_try = (base_try == TryMax) ? TryMax : base_try + 5'd1;
  assign exp_inc  = {1'b0, base_exp} + 5'd1;
  assign fire_exp = (exp_inc > {1'b0, cfg_i.max_exponent}) ? cfg_i.max_exponent
                                                            : exp_inc[3:0];

  // Wait draw: masked random times the unit period, times sixteen.
  assign mask     = (base_exp >= 4'd8) ? 8'hFF : ((8'd1 << base_exp[2:0]) - 8'd1);
  assign masked   = rnd_i & mask;
  assign prod     = (8 + PerW)'(masked) * (8 + PerW)'(UNIT_PERIOD);
  assign wait_val = {prod, 4'd0};
  assign cnt_dec  = cnt_q - CntW'(1);

  always_comb begin
    try_d      = try_q;
    exp_d      = exp_q;
    cnt_d      = cnt_q;
    counting_d = counting_q;
    outcome_d  = OutNone;
    case (cmd_i)
      CmdStart, CmdBusy: begin
        if ((cmd_i == CmdBusy) && (try_q > {1'b0, cfg_i.max_backoffs})) begin
          counting_d = 1'b0;
          cnt_d      = '0;
          outcome_d  = OutFail;
        end else if (masked == 8'd0) begin
          try_d      = fire_try;
          exp_d      = fire_exp;
          counting_d = 1'b0;
          cnt_d      = '0;
          outcome_d  = OutCca;
        end else begin
          try_d      = base_try;
          exp_d      = base_exp;
          counting_d = 1'b1;
          cnt_d      = wait_val;
        end
      end
      CmdTick: begin
        if (counting_q) begin
          if (cnt_dec == '0) begin
            try_d      = fire_try;
            exp_d      = fire_exp;
            counting_d = 1'b0;
            cnt_d      = '0;
            outcome_d  = OutCca;
          end else begin
            cnt_d = cnt_dec;
          end
        end
      end
      CmdIdle: begin
        counting_d = 1'b0;
        cnt_d      = '0;
        outcome_d  = OutOk;
      end
      CmdError: begin
        counting_d = 1'b0;
        cnt_d      = '0;
        outcome_d  = OutFail;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      try_q       <= '0;
      exp_q       <= '0;
      cnt_q       <= '0;
      counting_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        try_q      <= try_d;
        exp_q      <= exp_d;
        cnt_q      <= cnt_d;
        counting_q <= counting_d;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      outcome_q <= outcome_d;
      waiting_q <= counting_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign outcome_o   = outcome_q;
  assign waiting_o   = waiting_q;

`ifndef SYNTHESIS
  // A running countdown never sits at zero.
  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    counting_q |-> (cnt_q != '0))
    else $error("countdown is zero while counting");

  // Finished procedures and CCA requests leave no countdown running.
  a_done_not_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (outcome_q == OutOk || outcome_q == OutFail || outcome_q == OutCca))
      |-> !waiting_q)
    else $error("result reports waiting after a terminal outcome");

  // The waiting flag of a result matches the engine state it was taken from.
  a_waiting_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (out_valid_q && (waiting_q == counting_q)))
    else $error("result waiting flag disagrees with engine state");

  // A fired request always bumps the try count unless it is saturated.
  a_fire_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && (outcome_d == OutCca)) |=> (try_q != 5'd0))
    else $error("try count did not advance on a CCA request");
`endif

endmodule

/* rtl/csma_ca_backoff_controller.sv */
// Unslotted CSMA-CA backoff engine.
// The slave stream carries one command word per transfer: s_axis_tuser holds the
// command (start, tick, CCA idle, CCA busy, CCA error) and s_axis_tdata the random
// byte used whenever a backoff wait is drawn. Every accepted word produces exactly
// one result word on the master stream: the outcome (nothing, CCA request, done
// success, done fail) and a flag that is high while a backoff countdown runs.
// A word passes an input register, then the engine logic and the state update,
// then a result register. An accepted word waits in the input register, and the
// result register loads when the engine takes the word from there. One word
// is accepted per cycle for as long as the master side keeps up; the engine
// updates its state as it takes each word, which sets that rate.
// When the master side stalls, the result register holds its word and the input
// register absorbs one more word before s_axis_tready falls.
// Reset clears the engine state, empties both registers and loads the register
// defaults: max_backoffs 4, min_exponent 3, max_exponent 5. The APB port at
// byte addresses 0, 4 and 8 holds these three registers; write them only while
// the block is idle.
module csma_ca_backoff_controller import csma_pkg::*; #(
  parameter int unsigned UNIT_PERIOD = 20
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] random_value
  input  logic [2:0]  s_axis_tuser,   // [2:0] command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [1:0] outcome, [2] waiting, [7:3] zero
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t       cfg;
  logic       item_valid;
  logic       item_pop;
  logic [2:0] item_cmd;
  logic [7:0] item_rnd;
  logic [1:0] outcome;
  logic       waiting;

  csma_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  csma_in_stage u_in (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .s_cmd_i   (s_axis_tuser),
    .s_rnd_i   (s_axis_tdata),
    .valid_o   (item_valid),
    .pop_i     (item_pop),
    .cmd_o     (item_cmd),
    .rnd_o     (item_rnd)
  );

  csma_engine #(
    .UNIT_PERIOD (UNIT_PERIOD)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (item_valid),
    .in_pop_o    (item_pop),
    .cmd_i       (item_cmd),
    .rnd_i       (item_rnd),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .outcome_o   (outcome),
    .waiting_o   (waiting)
  );

  assign m_axis_tdata = {5'd0, waiting, outcome};

endmodule

/* tb/sv/tb_top.sv */
module tb_top;
  import csma_pkg::*;

  // The block under test runs with the default unit period; the predictor uses the same.
  localparam int UnitPeriod = 20;

  // Command words planned per register setting after the directed part.
  localparam int PhaseWords = 205;

  // The run is cut off here.
  localparam int CycleLimit = 500000;

  // Once this many command words have gone in, the receiver holds off for a long stretch.
  localparam int LongHoldAfter  = 500;
  localparam int LongHoldCycles = 64;

  // Register settings, one per phase: max_backoffs in [11:8], min_exponent in [7:4],
  // max_exponent in [3:0]. It covers all-zero, the most retries at exponent 8,
  // a minimum exponent above the maximum, and a return to the reset values at the end.
  localparam int NumPhases = 9;
  localparam logic [11:0] PhaseRegs [NumPhases] = '{
    12'h000, 12'hF88, 12'h235, 12'hF08, 12'h180, 12'h722, 12'h051, 12'hA04, 12'h435
  };

  // One command word: what the sender puts on tuser and tdata.
  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] rnd;
  } cmd_word_t;

  // One result word as the engine should report it.
  typedef struct packed {
    logic [1:0] outcome;
    logic       waiting;
  } result_word_t;

  // Engine state: try count, backoff exponent, remaining ticks of the wait, and
  // whether a countdown runs.
  typedef struct packed {
    logic [4:0]  tries;
    logic [3:0]  bexp;
    logic [23:0] remaining;
    logic        running;
  } backoff_state_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // [7:0] random_value
  logic [2:0]  s_axis_tuser = '0;   // [2:0] command
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;        // [1:0] outcome, [2] waiting, [7:3] zero
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  csma_ca_backoff_controller #(
    .UNIT_PERIOD(UnitPeriod)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // Register copy shared by the planner and the predictor. It only changes while the
  // block is idle, so both see the same values for every word of a phase.
  cfg_t regs = {MaxBackoffsRst, MinExponentRst, MaxExponentRst};

  // The planner runs its own engine copy ahead of the stream so that it knows how many
  // ticks a wait needs and when a CCA request is out. The predictor's copy advances
  // only on words the block has actually accepted.
  backoff_state_t plan_state  = '0;
  backoff_state_t model_state = '0;

  cmd_word_t    pending_words[$];
  result_word_t awaited_results[$];

  int  words_planned  = 0;
  int  words_accepted = 0;
  int  mismatches     = 0;
  int  cycle_count    = 0;
  bit  word_taken     = 1'b0;

  // Sender burst shaping.
  int  gap_left   = 0;
  int  burst_left = 1;

  // Receiver stall pattern.
  int  hold_left      = 0;
  bit  long_hold_done = 1'b0;
  int  mode_left      = 0;
  int  stall_pct      = 0;

  cmd_word_t    taken;
  result_word_t predicted;
  result_word_t want;

  // Bits of the random byte that take part in a draw at a given exponent. From an
  // exponent of eight on, the whole byte counts.
  function automatic logic [7:0] wait_mask(input logic [3:0] bexp);
    return (bexp >= 4'd8) ? 8'hFF : 8'hFF >> (4'd8 - bexp);
  endfunction

  // The backoff has run out: count a try, raise the exponent up to its ceiling and
  // ask for a channel assessment.
  function automatic logic [1:0] backoff_fire(inout backoff_state_t st);
    logic [4:0] raised;
    raised = {1'b0, st.bexp} + 5'd1;
    if (st.tries != TryMax) st.tries = st.tries + 5'd1;
    if (raised > {1'b0, regs.max_exponent}) raised = {1'b0, regs.max_exponent};
    st.bexp      = raised[3:0];
    st.running   = 1'b0;
    st.remaining = '0;
    return OutCca;
  endfunction

  // Draw a wait from the random byte. A zero wait fires on the spot.
  function automatic logic [1:0] backoff_draw(inout backoff_state_t st, input logic [7:0] rnd);
    logic [31:0] span;
    span = 32'(rnd & wait_mask(st.bexp)) * UnitPeriod * 16;
    if (span[23:0] == 24'd0) return backoff_fire(st);
    st.remaining = span[23:0];
    st.running   = 1'b1;
    return OutNone;
  endfunction

  // One command word through the engine; returns the outcome code. The waiting flag
  // of the result is the running bit left behind.
  function automatic logic [1:0] engine_step(inout backoff_state_t st, input logic [2:0] cmd,
                                             input logic [7:0] rnd);
    logic [1:0] res;
    res = OutNone;
    case (cmd)
      CmdStart: begin
        st.tries = '0;
        st.bexp  = regs.min_exponent;
        res      = backoff_draw(st, rnd);
      end
      CmdTick: begin
        if (st.running) begin
          st.remaining = st.remaining - 24'd1;
          if (st.remaining == 24'd0) res = backoff_fire(st);
        end
      end
      CmdIdle: begin
        st.running   = 1'b0;
        st.remaining = '0;
        res          = OutOk;
      end
      CmdBusy: begin
        if (st.tries <= {1'b0, regs.max_backoffs}) begin
          res = backoff_draw(st, rnd);
        end else begin
          st.running   = 1'b0;
          st.remaining = '0;
          res          = OutFail;
        end
      end
      CmdError: begin
        st.running   = 1'b0;
        st.remaining = '0;
        res          = OutFail;
      end
      default: ;  // Undefined commands leave the engine alone.
    endcase
    return res;
  endfunction

  // Random byte for a draw at the given exponent. Most draws mask to zero so the
  // procedure moves on at once, some give the shortest nonzero wait, which the
  // planner then ticks down, and the rest are fully random (usually long waits that
  // get interrupted).
  function automatic logic [7:0] pick_random_value(input logic [3:0] bexp);
    logic [7:0] mask;
    logic [7:0] r;
    int         pick;
    mask = wait_mask(bexp);
    r    = 8'($urandom_range(0, 255));
    pick = $urandom_range(0, 99);
    if (pick < 80) return r & ~mask;
    if (pick < 86) return (r & ~mask) | 8'd1;
    return r;
  endfunction

  // Append a word to the send queue and step the planning copy of the engine.
  function automatic logic [1:0] queue_word(input logic [2:0] cmd, input logic [7:0] rnd);
    cmd_word_t w;
    w.cmd = cmd;
    w.rnd = rnd;
    pending_words.push_back(w);
    words_planned++;
    return engine_step(plan_state, cmd, rnd);
  endfunction

  // APB write followed by a read-back of the same register. The write lands at the
  // rising edge of the access cycle.
  task automatic reg_write(input logic [1:0] idx, input logic [3:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {28'd0, val};
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      RegMaxBackoffs: regs.max_backoffs = val;
      RegMinExponent: regs.min_exponent = val;
      RegMaxExponent: regs.max_exponent = val;
      default: ;
    endcase
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata[3:0] !== val) begin
      $display("%0t: register %0d read back: expected %0d, actual %0d", $time, idx, val,
               prdata[3:0]);
      mismatches++;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Hold off until every planned word has gone in and every result has come back.
  task automatic drain_results();
    while (pending_words.size() != 0 || awaited_results.size() != 0 || s_axis_tvalid)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Word acceptance is recorded at the rising edge; the driver acts on it at the
  // following falling edge.
  always @(posedge clk_i) begin
    word_taken <= rst_ni && s_axis_tvalid && s_axis_tready;
  end

  // Driver. An accepted word is predicted here, so expectations are pushed on falling
  // edges and popped by the monitor on rising edges. A word on offer is held until it
  // is taken; new words go out in bursts with random gaps between them.
  always @(negedge clk_i) begin
    if (word_taken) begin
      taken             = pending_words.pop_front();
      predicted.outcome = engine_step(model_state, taken.cmd, taken.rnd);
      predicted.waiting = model_state.running;
      awaited_results.push_back(predicted);
      words_accepted++;
    end
    if (!s_axis_tvalid || word_taken) begin
      if (gap_left > 0) begin
        gap_left      <= gap_left - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pending_words.size() != 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= pending_words[0].cmd;
        s_axis_tdata  <= pending_words[0].rnd;
        if (burst_left > 1) begin
          burst_left <= burst_left - 1;
        end else begin
          // Half the bursts run straight into the next one.
          burst_left <= $urandom_range(1, 24);
          gap_left   <= ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver. It picks a stall rate for a stretch of cycles, from none to heavy, and
  // once in the run stops taking results for a long stretch so that the block backs up
  // into its input while the sender keeps offering.
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (!long_hold_done && words_accepted >= LongHoldAfter) begin
      long_hold_done <= 1'b1;
      hold_left      <= LongHoldCycles;
      m_axis_tready  <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        case ($urandom_range(0, 4))
          0, 1:    stall_pct = 0;
          2:       stall_pct = 25;
          3:       stall_pct = 60;
          default: stall_pct = 85;
        endcase
        mode_left = $urandom_range(16, 96);
      end
      mode_left     = mode_left - 1;
      m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Monitor. Every result word is checked field by field against the oldest
  // expectation; the padding bits of tdata must stay zero.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual tdata %h", $time,
                 m_axis_tdata);
        mismatches++;
      end else begin
        want = awaited_results.pop_front();
        if (m_axis_tdata[1:0] !== want.outcome) begin
          $display("%0t: outcome: expected %0d, actual %0d", $time, want.outcome,
                   m_axis_tdata[1:0]);
          mismatches++;
        end
        if (m_axis_tdata[2] !== want.waiting) begin
          $display("%0t: waiting: expected %0d, actual %0d", $time, want.waiting,
                   m_axis_tdata[2]);
          mismatches++;
        end
        if (m_axis_tdata[7:3] !== 5'd0) begin
          $display("%0t: padding: expected 0, actual %h", $time, m_axis_tdata[7:3]);
          mismatches++;
        end
      end
    end
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("** csma_ca_backoff_controller: FAILED **");
      $finish;
    end
  end

  // Stimulus: a directed opening at the reset register values, then one random phase
  // per register setting. Between phases the sender pauses until every result is back,
  // and the registers are rewritten only then.
  initial begin
    logic [1:0] res;
    int         n;
    int         pick;
    int         goal;
    cfg_t       phase_cfg;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // A tick with nothing running, the three undefined commands, and channel results
    // with no procedure under way. A busy report there draws at the reset exponent of
    // zero and so fires at once.
    void'(queue_word(CmdTick, 8'hFF));
    void'(queue_word(3'(CmdError + 3'd1), 8'h00));
    void'(queue_word(3'(CmdError + 3'd2), 8'hAA));
    void'(queue_word(3'(CmdError + 3'd3), 8'h55));
    void'(queue_word(CmdIdle, 8'h00));
    void'(queue_word(CmdBusy, 8'hFF));
    void'(queue_word(CmdError, 8'h0F));
    // A full procedure with zero waits: the exponent climbs to its ceiling and the
    // fifth busy report runs out of retries.
    void'(queue_word(CmdStart, 8'hF8));
    repeat (5) void'(queue_word(CmdBusy, 8'hE0));
    // Restart while counting, then channel reports that cut a running countdown.
    void'(queue_word(CmdStart, 8'hFF));
    void'(queue_word(CmdTick, 8'h00));
    void'(queue_word(CmdStart, 8'h01));
    void'(queue_word(CmdIdle, 8'h3C));
    void'(queue_word(CmdStart, 8'h02));
    void'(queue_word(CmdError, 8'hC3));
    void'(queue_word(CmdStart, 8'h04));
    void'(queue_word(CmdBusy, 8'h80));
    void'(queue_word(CmdStart, 8'h07));
    void'(queue_word(CmdBusy, 8'h05));
    void'(queue_word(CmdIdle, 8'h00));
    drain_results();

    for (int p = 0; p < NumPhases; p++) begin
      phase_cfg = cfg_t'(PhaseRegs[p]);
      reg_write(RegMaxBackoffs, phase_cfg.max_backoffs);
      reg_write(RegMinExponent, phase_cfg.min_exponent);
      reg_write(RegMaxExponent, phase_cfg.max_exponent);

      goal = words_planned + PhaseWords;
      while (words_planned < goal) begin
        if ($urandom_range(0, 9) == 0) begin
          // Stray word of any kind between procedures.
          void'(queue_word(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255))));
        end else begin
          // One procedure, followed until it reports success or failure.
          res = queue_word(CmdStart, pick_random_value(regs.min_exponent));
          while (res != OutOk && res != OutFail) begin
            if (plan_state.running) begin
              // Short waits that fit in what is left of the phase are usually ticked
              // all the way down; otherwise a few ticks go in and the countdown may get
              // cut short by some other command.
              if (plan_state.remaining <= 24'd400 &&
                  words_planned + int'(plan_state.remaining) <= goal &&
                  $urandom_range(0, 7) != 0)
                n = int'(plan_state.remaining);
              else
                n = $urandom_range(1, 8);
              repeat (n) res = queue_word(CmdTick, 8'($urandom_range(0, 255)));
              if (plan_state.running &&
                  (plan_state.remaining > 24'd400 || $urandom_range(0, 3) == 0)) begin
                pick = $urandom_range(0, 9);
                if (pick < 3)
                  res = queue_word(CmdStart, pick_random_value(regs.min_exponent));
                else if (pick < 5)
                  res = queue_word(CmdBusy, pick_random_value(plan_state.bexp));
                else if (pick < 7)
                  res = queue_word(CmdIdle, 8'($urandom_range(0, 255)));
                else if (pick < 8)
                  res = queue_word(CmdError, 8'($urandom_range(0, 255)));
                else
                  res = queue_word(3'(CmdError + $urandom_range(1, 3)),
                                   8'($urandom_range(0, 255)));
              end
            end else begin
              // A channel assessment is due; busy is the common answer.
              pick = $urandom_range(0, 19);
              if (pick < 12)
                res = queue_word(CmdBusy, pick_random_value(plan_state.bexp));
              else if (pick < 16)
                res = queue_word(CmdIdle, 8'($urandom_range(0, 255)));
              else if (pick < 18)
                res = queue_word(CmdError, 8'($urandom_range(0, 255)));
              else if (pick == 18)
                res = queue_word(3'(CmdError + $urandom_range(1, 3)),
                                 8'($urandom_range(0, 255)));
              else
                res = queue_word(CmdTick, 8'($urandom_range(0, 255)));
            end
          end
        end
      end
      drain_results();
    end

    repeat (8) @(posedge clk_i);
    if (mismatches == 0)
      $display("** csma_ca_backoff_controller: PASSED **");
    else
      $display("** csma_ca_backoff_controller: FAILED **");
    $finish;
  end

endmodule
